// ===== rtl/rmth_pkg.sv =====
// Package for the running median block: sizes, shared types and FSM states.
// Used by rmth_heap and running_median_two_heaps; depends on nothing.
package rmth_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int HEAP_DEPTH  = CAPACITY / 2 + 1;
    localparam int HIDX_W      = $clog2(HEAP_DEPTH);
    localparam int HCNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int TOT_W       = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic signed [VALUE_WIDTH:0]   t_twice;
    typedef logic [HCNT_W-1:0]             t_hcnt;
    typedef logic [HIDX_W-1:0]             t_hidx;

    typedef struct packed {
        logic   clear;
        logic   push;
        logic   repl;
        t_value val;
    } t_heap_cmd;

    typedef struct packed {
        logic   busy;
        t_hcnt  cnt;
        t_value top;
    } t_heap_sts;

    typedef enum logic [1:0] {
        HP_IDLE,
        HP_UP,
        HP_DOWN,
        HP_PUT
    } t_hp_state;

    typedef enum logic {
        RM_IDLE,
        RM_RUN
    } t_rm_state;

endpackage

// ===== rtl/rmth_heap.sv =====
// One binary heap in a synchronous memory: push with sift-up, replace-top with sift-down.
// Depends on rmth_pkg.
module rmth_heap (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_is_max,
    input  rmth_pkg::t_heap_cmd i_cmd,
    output rmth_pkg::t_heap_sts o_sts
);
    import rmth_pkg::*;

    t_value    mem [HEAP_DEPTH];
    t_value    r_rd0, r_rd1;
    t_hp_state r_state, n_state;
    t_hidx     r_idx, n_idx;
    t_value    r_val, n_val;
    t_hcnt     r_cnt, n_cnt;
    t_value    r_top;

    logic      we;
    t_hidx     wa, ra0, ra1;
    t_value    wd;

    t_hcnt                ec;
    t_hidx                par;
    logic [HIDX_W+1:0]    lch, rch, nl;
    logic                 rv, pick_r;
    t_hidx                best;
    t_value               bestv;

    function automatic logic above(input t_value a, input t_value b, input logic is_max);
        above = is_max ? (a > b) : (a < b);
    endfunction

    always_comb begin
        ec     = i_cmd.clear ? '0 : r_cnt;
        par    = t_hidx'((r_idx - 1'b1) >> 1);
        lch    = {1'b0, r_idx, 1'b1};
        rch    = lch + 1'b1;
        rv     = rch < (HIDX_W+2)'(r_cnt);
        pick_r = rv && above(r_rd1, r_rd0, i_is_max);
        best   = pick_r ? rch[HIDX_W-1:0] : lch[HIDX_W-1:0];
        bestv  = pick_r ? r_rd1 : r_rd0;
        nl     = {1'b0, best, 1'b1};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            HP_IDLE: begin
                if (i_cmd.push && ec != '0) begin
                    n_state = HP_UP;
                end else if (i_cmd.repl && ec > t_hcnt'(1)) begin
                    n_state = HP_DOWN;
                end
            end
            HP_UP: begin
                if (!above(r_val, r_rd0, i_is_max)) begin
                    n_state = HP_IDLE;
                end else if (par == '0) begin
                    n_state = HP_PUT;
                end
            end
            HP_DOWN: begin
                if (!above(bestv, r_val, i_is_max)) begin
                    n_state = HP_IDLE;
                end else if (nl >= (HIDX_W+2)'(r_cnt)) begin
                    n_state = HP_PUT;
                end
            end
            HP_PUT: n_state = HP_IDLE;
            default: n_state = HP_IDLE;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        wa    = r_idx;
        wd    = r_val;
        ra0   = '0;
        ra1   = '0;
        n_idx = r_idx;
        n_val = r_val;
        n_cnt = r_cnt;
        unique case (r_state)
            HP_IDLE: begin
                n_val = i_cmd.val;
                if (i_cmd.push) begin
                    n_cnt = ec + 1'b1;
                    n_idx = ec[HIDX_W-1:0];
                    ra0   = t_hidx'((ec - 1'b1) >> 1);
                    if (ec == '0) begin
                        we = 1'b1;
                        wa = '0;
                        wd = i_cmd.val;
                    end
                end else if (i_cmd.repl) begin
                    n_cnt = ec;
                    n_idx = '0;
                    ra0   = t_hidx'(1);
                    ra1   = t_hidx'(2);
                    if (ec <= t_hcnt'(1)) begin
                        we = 1'b1;
                        wa = '0;
                        wd = i_cmd.val;
                    end
                end else if (i_cmd.clear) begin
                    n_cnt = '0;
                end
            end
            HP_UP: begin
                we = 1'b1;
                if (above(r_val, r_rd0, i_is_max)) begin
                    wd    = r_rd0;
                    n_idx = par;
                    ra0   = t_hidx'((par - 1'b1) >> 1);
                end
            end
            HP_DOWN: begin
                we = 1'b1;
                if (above(bestv, r_val, i_is_max)) begin
                    wd    = bestv;
                    n_idx = best;
                    ra0   = nl[HIDX_W-1:0];
                    ra1   = t_hidx'(nl + 1'b1);
                end
            end
            HP_PUT: we = 1'b1;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd0 <= mem[ra0];
        r_rd1 <= mem[ra1];
        if (we && wa == '0) begin
            r_top <= wd;
        end
        r_idx <= n_idx;
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HP_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_sts.busy = (r_state != HP_IDLE);
    assign o_sts.cnt  = r_cnt;
    assign o_sts.top  = r_top;

endmodule

// ===== rtl/running_median_two_heaps.sv =====
// Running median over a signed stream: max-heap of the lower half, min-heap of the upper half.
// Each heap sits in its own memory (rmth_heap); both sift in parallel. Depends on rmth_pkg.
// A value is taken in idle; both heaps then sift in parallel (one level per cycle; none for the
// first value of a sequence) and the median is registered once the longer sift is done.
// No new value is taken before that; a full store answers from the held median, with no sift.
// Reset clears counts, held median and FSMs; heap memories are not cleared.
module running_median_two_heaps (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] median
    output logic [0:0]  m_tuser    // [0] overflow
);
    import rmth_pkg::*;

    t_rm_state r_state, n_state;
    t_twice    r_tm, n_tm;
    logic [TOT_W-1:0] r_tot, n_tot;
    logic      r_mvalid, n_mvalid;
    logic [31:0] r_med, n_med;
    logic      r_ovf, n_ovf;

    t_heap_cmd lcmd, ucmd;
    t_heap_sts lsts, usts;

    logic             acc, rst_seq, full, first;
    t_value           x;
    t_twice           x2, tm_new, tm_half;
    t_hcnt            lc, uc;
    logic [TOT_W-1:0] te;

    function automatic logic [31:0] half32(input t_twice t);
        t_twice h;
        h = (t + t_twice'(t[VALUE_WIDTH])) >>> 1;
        half32 = 32'(signed'(h[VALUE_WIDTH-1:0]));
    endfunction

    assign s_tready = (r_state == RM_IDLE) && (!r_mvalid || m_tready);
    assign acc      = s_tvalid && s_tready;
    assign x        = t_value'(s_tdata[VALUE_WIDTH-1:0]);
    assign x2       = {x, 1'b0};
    assign rst_seq  = s_tuser[0];
    assign lc       = rst_seq ? '0 : lsts.cnt;
    assign uc       = rst_seq ? '0 : usts.cnt;
    assign te       = rst_seq ? '0 : r_tot;
    assign full     = te >= TOT_W'(CAPACITY);
    assign first    = te == '0;

    always_comb begin
        if (lsts.cnt == usts.cnt) begin
            tm_new = t_twice'(lsts.top) + t_twice'(usts.top);
        end else if (lsts.cnt > usts.cnt) begin
            tm_new = {lsts.top, 1'b0};
        end else begin
            tm_new = {usts.top, 1'b0};
        end
        tm_half = tm_new;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RM_IDLE: if (acc && !full) n_state = RM_RUN;
            RM_RUN:  if (!lsts.busy && !usts.busy) n_state = RM_IDLE;
            default: n_state = RM_IDLE;
        endcase
    end

    always_comb begin
        lcmd       = '0;
        ucmd       = '0;
        lcmd.clear = acc && rst_seq;
        ucmd.clear = acc && rst_seq;
        n_tm       = r_tm;
        n_tot      = r_tot;
        n_mvalid   = r_mvalid && !m_tready;
        n_med      = r_med;
        n_ovf      = r_ovf;
        unique case (r_state)
            RM_IDLE: begin
                if (acc) begin
                    if (full) begin
                        n_mvalid = 1'b1;
                        n_med    = half32(r_tm);
                        n_ovf    = 1'b1;
                    end else begin
                        n_tot = te + 1'b1;
                        if (first) begin
                            lcmd.push = 1'b1;
                            lcmd.val  = x;
                        end else if (lc > uc) begin
                            if (x2 < r_tm) begin
                                lcmd.repl = 1'b1;
                                lcmd.val  = x;
                                ucmd.push = 1'b1;
                                ucmd.val  = lsts.top;
                            end else begin
                                ucmd.push = 1'b1;
                                ucmd.val  = x;
                            end
                        end else if (lc == uc) begin
                            if (x2 < r_tm) begin
                                lcmd.push = 1'b1;
                                lcmd.val  = x;
                            end else begin
                                ucmd.push = 1'b1;
                                ucmd.val  = x;
                            end
                        end else begin
                            if (x2 > r_tm) begin
                                ucmd.repl = 1'b1;
                                ucmd.val  = x;
                                lcmd.push = 1'b1;
                                lcmd.val  = usts.top;
                            end else begin
                                lcmd.push = 1'b1;
                                lcmd.val  = x;
                            end
                        end
                    end
                end
            end
            RM_RUN: begin
                if (!lsts.busy && !usts.busy) begin
                    n_tm     = tm_new;
                    n_mvalid = 1'b1;
                    n_med    = half32(tm_half);
                    n_ovf    = 1'b0;
                end
            end
            default: n_tm = r_tm;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= RM_IDLE;
            r_tm     <= '0;
            r_tot    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tm     <= n_tm;
            r_tot    <= n_tot;
            r_mvalid <= n_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_med <= n_med;
        r_ovf <= n_ovf;
    end

    rmth_heap u_lower (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_is_max(1'b1),
        .i_cmd   (lcmd),
        .o_sts   (lsts)
    );

    rmth_heap u_upper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_is_max(1'b0),
        .i_cmd   (ucmd),
        .o_sts   (usts)
    );

    assign m_tvalid   = r_mvalid;
    assign m_tdata    = r_med;
    assign m_tuser[0] = r_ovf;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for running_median_two_heaps: streams signed values with restarts and
// checks each median/overflow beat against a sorted-list predictor. Depends on rmth_pkg.
module tb_top;
    import rmth_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic [0:0]  s_tuser;   // [0] restart
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] median
    logic [0:0]  m_tuser;   // [0] overflow

    running_median_two_heaps dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    typedef struct packed {
        logic [31:0] median;
        logic        overflow;
    } t_median_beat;

    // predictor state: plain sorted list of values in the current sequence
    longint      seq_vals[$];
    longint      held_twice;
    t_median_beat median_q[$];
    int          mismatches;
    bit          stall_on;
    int          ready_hold;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // sequence order: lower half (max-heap) and upper half (min-heap) as sorted list
    function automatic void predict_median(logic [31:0] val, logic restart);
        longint x;
        longint lo_top, hi_top;
        int n, pos;
        t_median_beat b;
        x = longint'($signed(val));
        if (restart) begin
            seq_vals.delete();
            held_twice = 0;
        end
        b.overflow = 1'b0;
        if (seq_vals.size() >= CAPACITY) begin
            b.overflow = 1'b1;
        end else begin
            pos = 0;
            while (pos < seq_vals.size() && seq_vals[pos] <= x) pos++;
            seq_vals.insert(pos, x);
            n = seq_vals.size();
            if (n % 2) begin
                held_twice = 2 * seq_vals[n / 2];
            end else begin
                lo_top = seq_vals[n / 2 - 1];
                hi_top = seq_vals[n / 2];
                held_twice = lo_top + hi_top;
            end
        end
        b.median = 32'(held_twice / 2);
        median_q.insert(median_q.size(), b);
    endfunction

    // called at a falling edge; leaves tvalid high until the next call or the end
    task automatic send_value(logic [31:0] val, logic restart);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= restart;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_median(val, restart);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (median_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: median=%0d ovf=%0d",
                             $signed(m_tdata), m_tuser);
            end else if (median_q[0].median !== m_tdata ||
                         median_q[0].overflow !== m_tuser[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp median=%0d ovf=%0d, got median=%0d ovf=%0d",
                             $signed(median_q[0].median), median_q[0].overflow,
                             $signed(m_tdata), m_tuser);
                void'(median_q.pop_front());
            end else begin
                void'(median_q.pop_front());
            end
        end
    end

    // mostly short ready gaps, now and then a long stall
    always @(negedge i_clk) begin
        if (!stall_on) begin
            m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 3) begin
            ready_hold = $urandom_range(5, 40);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'hffff_ffff, 1'b1);
        send_value(32'h0000_0000, 1'b0);
        send_value(32'h0000_0002, 1'b0);
        send_value(32'hffff_fffd, 1'b0);
        send_value(32'h0000_0005, 1'b1);
        send_value(32'h0000_0005, 1'b0);
        send_value(32'h0000_0004, 1'b0);
        send_value(32'h0000_0006, 1'b0);
        send_value(32'h5555_5555, 1'b1);
        send_value(32'haaaa_aaaa, 1'b0);
    endtask

    task automatic test_random_runs();
        for (int i = 0; i < 370; i++)
            send_value(rand_value(), ($urandom_range(0, 39) == 0));
    endtask

    // fill the store, then push into overflow, then restart out of it
    task automatic test_overflow();
        send_value($urandom, 1'b1);
        for (int i = 1; i < CAPACITY; i++) send_value(rand_value(), 1'b0);
        for (int i = 0; i < 6; i++) send_value($urandom, 1'b0);
        send_value(32'h0000_0007, 1'b1);
        send_value(32'hffff_fff0, 1'b0);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        stall_on   = 1'b0;
        ready_hold = 0;
        mismatches = 0;
        held_twice = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        stall_on = 1'b1;
        test_random_runs();
        test_overflow();
        s_tvalid <= 1'b0;
        while (median_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("running_median_two_heaps test passed");
        end else begin
            $display("running_median_two_heaps test failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("running_median_two_heaps test failed");
        $finish;
    end
endmodule
